// File: hdl/db_level_to_color_map_core_assert.svh
// Assertion macros used by the level-to-color map RTL.
`ifndef DB_LEVEL_TO_COLOR_MAP_CORE_ASSERT_SVH
`define DB_LEVEL_TO_COLOR_MAP_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define DLCM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dlcm: implication check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define DLCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dlcm: next-cycle check failed");

`endif

// File: hdl/dlcm_pkg.sv
// Types and constants of the level-to-color map block.
`default_nettype none

package dlcm_pkg;

    // Field widths.
    localparam int MAG_W   = 17;
    localparam int RANGE_W = 16;
    localparam int MAP_W   = 3;
    localparam int FRAC_W  = 16;
    localparam int CHAN_W  = 8;
    localparam int IDX_W   = 2;

    // One quotient bit per divider stage; latency from accept to the done strobe.
    localparam int DIV_STAGES = FRAC_W;
    localparam int LATENCY    = DIV_STAGES + 3;

    // Fraction constants, 65536 means 1.0.
    localparam logic [FRAC_W:0] FRAC_ONE  = 17'h10000;
    localparam logic [FRAC_W:0] FRAC_HALF = 17'h08000;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_PEAK  = 2'd0;
    localparam logic [IDX_W-1:0] REG_RANGE = 2'd1;
    localparam logic [IDX_W-1:0] REG_MAP   = 2'd2;

    // Reset values of the registers.
    localparam logic [MAG_W-1:0]   PEAK_RST  = 17'd0;
    localparam logic [RANGE_W-1:0] RANGE_RST = 16'd17920;

    // Color map codes; the remaining codes fall back to gray.
    localparam logic [MAP_W-1:0] MAP_GRAY    = 3'd0;
    localparam logic [MAP_W-1:0] MAP_JET     = 3'd1;
    localparam logic [MAP_W-1:0] MAP_HOT     = 3'd2;
    localparam logic [MAP_W-1:0] MAP_COOL    = 3'd3;
    localparam logic [MAP_W-1:0] MAP_VIRIDIS = 3'd4;

    // Jet segment codes.
    localparam logic [1:0] JET_BLUE   = 2'd0;
    localparam logic [1:0] JET_CYAN   = 2'd1;
    localparam logic [1:0] JET_YELLOW = 2'd2;
    localparam logic [1:0] JET_RED    = 2'd3;

    // Hot segment codes and break points (first fraction of the next segment).
    localparam logic [1:0] HOT_RED    = 2'd0;
    localparam logic [1:0] HOT_YELLOW = 2'd1;
    localparam logic [1:0] HOT_WHITE  = 2'd2;
    localparam logic [FRAC_W:0] HOT_BRK1 = 17'd21627;
    localparam logic [FRAC_W:0] HOT_BRK2 = 17'd43254;

    // Hot arithmetic: red and green are floor((f*2125 - ofs) / 2^14 / 11),
    // blue is (f*375 - ofs) / 2^15. Division by 11 uses a 2^16 reciprocal.
    localparam logic [27:0] HOT_MUL_RG = 28'd2125;
    localparam logic [27:0] HOT_G_OFS  = 28'd45957120;
    localparam logic [24:0] HOT_MUL_B  = 25'd375;
    localparam logic [24:0] HOT_B_OFS  = 25'd16220160;
    localparam logic [24:0] DIV11_MUL  = 25'd5958;

    // Viridis corner colors and slopes.
    localparam logic [CHAN_W-1:0] VIR_LO_B  = 8'd68;
    localparam logic [CHAN_W-1:0] VIR_MID_R = 8'd68;
    localparam logic [CHAN_W-1:0] VIR_MID_G = 8'd1;
    localparam logic [CHAN_W-1:0] VIR_MID_B = 8'd84;
    localparam logic [22:0] VIR_LO_R_MUL = 23'd68;
    localparam logic [23:0] VIR_UP_R_MUL = 24'd185;
    localparam logic [23:0] VIR_UP_G_MUL = 24'd230;
    localparam logic [21:0] VIR_UP_B_MUL = 22'd47;
    localparam logic [21:0] VIR_UP_B_RND = 22'd32767;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // Control word that travels with each item through the divider.
    typedef struct packed {
        logic valid;
        logic force_zero;
        logic force_one;
    } dlcm_ctl_t;

endpackage

`default_nettype wire

// File: hdl/db_level_to_color_map_core.sv
// Top level: spectrogram dB level to RGB pixel through a selectable color map.
//
//  Channel   Handshake                 Word
//  input     start / busy              magnitude_level
//  result    done (one-cycle strobe)   red, green, blue
//  config    cfg_write                 cfg_index, cfg_data
//
// A word is taken every clock cycle while busy is low; its pixel leaves through
// one setup stage, sixteen divider stages, one map stage and one output stage.
// The sixteen-stage restoring divider that forms the level fraction sets the latency.
// busy is high only during reset and the cycle after it; then it stays low.
// The receiver cannot stall, so the pipeline never holds; done marks each pixel.
`default_nettype none

module db_level_to_color_map_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [dlcm_pkg::MAG_W-1:0]   magnitude_level,
    input  logic                                cfg_write,
    input  logic [dlcm_pkg::IDX_W-1:0]          cfg_index,
    input  logic [dlcm_pkg::MAG_W-1:0]          cfg_data,
    output logic                                done,
    output logic [dlcm_pkg::CHAN_W-1:0]         red,
    output logic [dlcm_pkg::CHAN_W-1:0]         green,
    output logic [dlcm_pkg::CHAN_W-1:0]         blue
);
    import dlcm_pkg::*;

    `include "db_level_to_color_map_core_assert.svh"

    // Configuration registers.
    logic signed [MAG_W-1:0] peak_level_reg;
    logic [RANGE_W-1:0]      dynamic_range_reg;
    logic [MAP_W-1:0]        color_map_reg;
    logic                    busy_reg;
    logic                    accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_level_reg    <= PEAK_RST;
            dynamic_range_reg <= RANGE_RST;
            color_map_reg     <= MAP_GRAY;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PEAK:  peak_level_reg    <= cfg_data;
                REG_RANGE: dynamic_range_reg <= cfg_data[RANGE_W-1:0];
                REG_MAP:   color_map_reg     <= cfg_data[MAP_W-1:0];
                default:   ;
            endcase
        end
    end

    // Busy only while coming out of reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    // Setup stage: offset into the display window and the clamp decision.
    logic signed [MAG_W+1:0] mag_ext;
    logic signed [MAG_W+1:0] peak_ext;
    logic signed [MAG_W+1:0] range_ext;
    logic signed [MAG_W+1:0] offset;
    logic                    mag_ge_peak;
    dlcm_ctl_t               setup_next;
    dlcm_ctl_t               setup_reg;
    logic [RANGE_W-1:0]      dividend_reg;

    assign mag_ext     = (MAG_W+2)'(magnitude_level);
    assign peak_ext    = (MAG_W+2)'(peak_level_reg);
    assign range_ext   = $signed({3'b000, dynamic_range_reg});
    assign offset      = mag_ext - peak_ext + range_ext;
    assign mag_ge_peak = magnitude_level >= peak_level_reg;

    // At or above the peak the fraction is one; zero at or below the window floor.
    always_comb
    begin
        setup_next.valid      = accept;
        setup_next.force_one  = mag_ge_peak;
        setup_next.force_zero = !mag_ge_peak &&
                                ((dynamic_range_reg == '0) || offset[MAG_W+1] ||
                                 (offset == '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_reg <= '0;
        end
        else
        begin
            setup_reg <= setup_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= offset[RANGE_W-1:0];
    end

    // Fraction = floor(offset * 65536 / range).
    dlcm_ctl_t       div_ctl;
    logic [FRAC_W:0] frac;

    dlcm_frac_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (setup_reg),
        .dividend (dividend_reg),
        .divisor  (dynamic_range_reg),
        .ctl_out  (div_ctl),
        .frac     (frac)
    );

    // Map stage: per-map channel values from the fraction.
    logic [24:0]        gray_prod;
    logic [FRAC_W:0]    inv_frac;
    logic [24:0]        cool_prod;
    logic [1:0]         jet_seg_next;
    logic [14:0]        jet_span;
    logic [22:0]        jet_prod;
    logic [1:0]         hot_seg_next;
    logic [27:0]        hot_rg_prod;
    logic [24:0]        hot_b_prod;
    logic               vir_upper;
    logic [15:0]        vir_u;
    logic [21:0]        vir_lo_r_prod;
    logic [23:0]        vir_up_r_prod;
    logic [23:0]        vir_up_g_prod;
    logic [21:0]        vir_up_b_prod;
    logic [CHAN_W-1:0]  vir_r_next;
    logic [CHAN_W-1:0]  vir_g_next;
    logic [CHAN_W-1:0]  vir_b_next;

    assign gray_prod = 25'(frac) * 25'd255;
    assign inv_frac  = FRAC_ONE - frac;
    assign cool_prod = 25'(inv_frac) * 25'd255;

    // Jet: four quarter segments, each a 0..16384 span scaled to 0..255.
    assign jet_seg_next = frac[FRAC_W] ? JET_RED : frac[FRAC_W-1:FRAC_W-2];

    always_comb
    begin
        unique case (jet_seg_next)
            JET_BLUE:   jet_span = 15'(frac[FRAC_W-3:0]);
            JET_CYAN:   jet_span = 15'(FRAC_HALF - frac);
            JET_YELLOW: jet_span = 15'(frac - FRAC_HALF);
            JET_RED:    jet_span = 15'(FRAC_ONE - frac);
        endcase
    end

    assign jet_prod = 23'(jet_span) * 23'd255;

    // Hot: break points at 0.33 and 0.66 of full scale.
    always_comb
    begin
        priority if (frac < HOT_BRK1)
        begin
            hot_seg_next = HOT_RED;
        end
        else if (frac < HOT_BRK2)
        begin
            hot_seg_next = HOT_YELLOW;
        end
        else
        begin
            hot_seg_next = HOT_WHITE;
        end
    end

    assign hot_rg_prod = 28'(frac) * HOT_MUL_RG -
                         ((hot_seg_next == HOT_YELLOW) ? HOT_G_OFS : 28'd0);
    assign hot_b_prod  = 25'(frac) * HOT_MUL_B - HOT_B_OFS;

    // Viridis: two linear halves meeting at the midpoint color.
    assign vir_upper     = frac >= FRAC_HALF;
    assign vir_u         = 16'(frac - FRAC_HALF);
    assign vir_lo_r_prod = 22'(frac[FRAC_W-2:0]) * 22'(VIR_LO_R_MUL);
    assign vir_up_r_prod = 24'(vir_u) * VIR_UP_R_MUL;
    assign vir_up_g_prod = 24'(vir_u) * VIR_UP_G_MUL;
    assign vir_up_b_prod = 22'(vir_u) * VIR_UP_B_MUL + VIR_UP_B_RND;

    always_comb
    begin
        if (vir_upper)
        begin
            vir_r_next = VIR_MID_R + vir_up_r_prod[22:15];
            vir_g_next = VIR_MID_G + vir_up_g_prod[22:15];
            vir_b_next = VIR_MID_B - CHAN_W'(vir_up_b_prod[20:15]);
        end
        else
        begin
            vir_r_next = CHAN_W'(vir_lo_r_prod[21:15]);
            vir_g_next = '0;
            vir_b_next = VIR_LO_B + CHAN_W'(frac[FRAC_W-2:FRAC_W-5]);
        end
    end

    logic               map_valid_reg;
    logic [CHAN_W-1:0]  gray_v_reg;
    logic [CHAN_W-1:0]  cool_g_reg;
    logic [CHAN_W-1:0]  jet_v_reg;
    logic [1:0]         jet_seg_reg;
    logic [11:0]        hot_t_reg;
    logic [1:0]         hot_seg_reg;
    logic [CHAN_W-1:0]  hot_b_reg;
    logic [CHAN_W-1:0]  vir_r_reg;
    logic [CHAN_W-1:0]  vir_g_reg;
    logic [CHAN_W-1:0]  vir_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_valid_reg <= 1'b0;
        end
        else
        begin
            map_valid_reg <= div_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        gray_v_reg  <= gray_prod[23:16];
        cool_g_reg  <= cool_prod[23:16];
        jet_v_reg   <= jet_prod[21:14];
        jet_seg_reg <= jet_seg_next;
        hot_t_reg   <= hot_rg_prod[25:14];
        hot_seg_reg <= hot_seg_next;
        hot_b_reg   <= hot_b_prod[22:15];
        vir_r_reg   <= vir_r_next;
        vir_g_reg   <= vir_g_next;
        vir_b_reg   <= vir_b_next;
    end

    // Output stage: finish the hot division by 11 and pick the map.
    logic [24:0]        hot_q_prod;
    logic [CHAN_W-1:0]  hot_q;
    logic [CHAN_W-1:0]  red_next;
    logic [CHAN_W-1:0]  green_next;
    logic [CHAN_W-1:0]  blue_next;
    logic               done_reg;
    logic [CHAN_W-1:0]  red_reg;
    logic [CHAN_W-1:0]  green_reg;
    logic [CHAN_W-1:0]  blue_reg;

    assign hot_q_prod = 25'(hot_t_reg) * DIV11_MUL;
    assign hot_q      = hot_q_prod[23:16];

    always_comb
    begin
        red_next   = gray_v_reg;
        green_next = gray_v_reg;
        blue_next  = gray_v_reg;
        unique case (color_map_reg)
            MAP_JET:
            begin
                unique case (jet_seg_reg)
                    JET_BLUE:
                    begin
                        red_next   = '0;
                        green_next = jet_v_reg;
                        blue_next  = CHAN_MAX;
                    end
                    JET_CYAN:
                    begin
                        red_next   = '0;
                        green_next = CHAN_MAX;
                        blue_next  = jet_v_reg;
                    end
                    JET_YELLOW:
                    begin
                        red_next   = jet_v_reg;
                        green_next = CHAN_MAX;
                        blue_next  = '0;
                    end
                    JET_RED:
                    begin
                        red_next   = CHAN_MAX;
                        green_next = jet_v_reg;
                        blue_next  = '0;
                    end
                endcase
            end
            MAP_HOT:
            begin
                unique case (hot_seg_reg)
                    HOT_RED:
                    begin
                        red_next   = hot_q;
                        green_next = '0;
                        blue_next  = '0;
                    end
                    HOT_YELLOW:
                    begin
                        red_next   = CHAN_MAX;
                        green_next = hot_q;
                        blue_next  = '0;
                    end
                    default:
                    begin
                        red_next   = CHAN_MAX;
                        green_next = CHAN_MAX;
                        blue_next  = hot_b_reg;
                    end
                endcase
            end
            MAP_COOL:
            begin
                red_next   = gray_v_reg;
                green_next = cool_g_reg;
                blue_next  = CHAN_MAX;
            end
            MAP_VIRIDIS:
            begin
                red_next   = vir_r_reg;
                green_next = vir_g_reg;
                blue_next  = vir_b_reg;
            end
            default:
            begin
                red_next   = gray_v_reg;
                green_next = gray_v_reg;
                blue_next  = gray_v_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= map_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

    // Terms shared by the checks below.
    logic gray_done;
    logic peak_word_in;
    logic white_pixel;

    assign gray_done    = done && (color_map_reg == MAP_GRAY);
    assign peak_word_in = accept && mag_ge_peak;
    assign white_pixel  = (red == CHAN_MAX) && (green == CHAN_MAX) && (blue == CHAN_MAX);

    // Every pixel comes from a word that the block took.
    `DLCM_ASSERT_IMP(a_done_from_accept, done, $past(accept, LATENCY))
    // A level at or above the peak is full white on the gray map.
    `DLCM_ASSERT_IMP(a_gray_peak_white, gray_done && $past(peak_word_in, LATENCY), white_pixel)
    // The gray map gives equal channels.
    `DLCM_ASSERT_IMP(a_gray_equal, gray_done, (red == green) && (green == blue))
    // Once out of reset the block never reports busy again.
    `DLCM_ASSERT_NEXT(a_busy_stays_low, !busy, !busy)

endmodule

`default_nettype wire

// File: hdl/dlcm_frac_div.sv
// Pipelined restoring divider giving the 17-bit level fraction.
`default_nettype none

module dlcm_frac_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dlcm_pkg::dlcm_ctl_t              ctl_in,
    input  logic [dlcm_pkg::RANGE_W-1:0]     dividend,
    input  logic [dlcm_pkg::RANGE_W-1:0]     divisor,
    output dlcm_pkg::dlcm_ctl_t              ctl_out,
    output logic [dlcm_pkg::FRAC_W:0]        frac
);
    import dlcm_pkg::*;

    // One register stage per quotient bit, most significant bit first.
    dlcm_ctl_t            ctl_reg [1:DIV_STAGES];
    logic [RANGE_W-1:0]   rem_reg [1:DIV_STAGES];
    logic [FRAC_W-1:0]    quo_reg [1:DIV_STAGES];

    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
        dlcm_ctl_t          ctl_prev;
        logic [RANGE_W-1:0] rem_prev;
        logic [FRAC_W-1:0]  quo_prev;
        logic [RANGE_W:0]   rem_dbl;
        logic               take;
        logic [RANGE_W-1:0] rem_next;
        logic [FRAC_W-1:0]  quo_next;

        if (k == 1) begin : g_first
            assign ctl_prev = ctl_in;
            assign rem_prev = dividend;
            assign quo_prev = '0;
        end
        else begin : g_rest
            assign ctl_prev = ctl_reg[k-1];
            assign rem_prev = rem_reg[k-1];
            assign quo_prev = quo_reg[k-1];
        end

        // Shift the partial remainder and subtract the divisor where it fits.
        assign rem_dbl  = {rem_prev, 1'b0};
        assign take     = rem_dbl >= {1'b0, divisor};
        assign rem_next = take ? RANGE_W'(rem_dbl - {1'b0, divisor}) : RANGE_W'(rem_dbl);
        assign quo_next = {quo_prev[FRAC_W-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else
            begin
                ctl_reg[k] <= ctl_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            quo_reg[k] <= quo_next;
        end
    end

    // Clamped levels bypass the quotient.
    assign ctl_out = ctl_reg[DIV_STAGES];

    always_comb
    begin
        priority if (ctl_reg[DIV_STAGES].force_one)
        begin
            frac = FRAC_ONE;
        end
        else if (ctl_reg[DIV_STAGES].force_zero)
        begin
            frac = '0;
        end
        else
        begin
            frac = {1'b0, quo_reg[DIV_STAGES]};
        end
    end

endmodule

`default_nettype wire
